@@ design/bfrp_pkg.sv @@
// Shared types and constants for the body-frame relative position block.
package bfrp_pkg;

    // Fraction bits of the rotation matrix elements.
    localparam int MAT_FRAC = 28;

    // Control word from the sequencer to a serial multiply-accumulate lane.
    typedef struct packed {
        logic clr;   // clear accumulator before a new product
        logic en;    // consume one multiplier bit
        logic last;  // multiplier sign bit: subtract instead of add
    } mac_ctl_t;

endpackage

@@ design/bfrp_mac.sv @@
// Bit-serial multiply-accumulate lane: sum of three signed products, one multiplier bit a cycle while ctl.en is high.
module bfrp_mac
    import bfrp_pkg::*;
#(
    parameter int AW = 35,
    parameter int NB = 33
) (
    input  logic                     aclk,
    input  mac_ctl_t                 ctl,
    input  logic signed [AW-1:0]     a0,
    input  logic signed [AW-1:0]     a1,
    input  logic signed [AW-1:0]     a2,
    input  logic [2:0]               b,
    output logic signed [AW+4+NB-1:0] prod
);

    localparam int HW = AW + 4;

    logic signed [HW-1:0] hi_reg;
    logic signed [HW-1:0] hi_next;
    logic [NB-1:0]        lo_reg;
    logic [NB-1:0]        lo_next;
    logic signed [HW-1:0] t0, t1, t2, part, sum;

    always_comb begin
        t0      = b[0] ? HW'(a0) : '0;
        t1      = b[1] ? HW'(a1) : '0;
        t2      = b[2] ? HW'(a2) : '0;
        part    = t0 + t1 + t2;
        sum     = ctl.last ? (hi_reg - part) : (hi_reg + part);
        hi_next = sum >>> 1;
        lo_next = {sum[0], lo_reg[NB-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (ctl.en) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign prod = {hi_reg, lo_reg};

endmodule

@@ design/body_frame_relative_position.sv @@
// Top level of the body-frame relative position block.
//
// Two words arrive on the s_ channel. A vehicle pose word (s_kind bit 0 low)
// stores the vehicle position and attitude and gives no result; the block then
// rebuilds its rotation matrix with nine bit-serial quaternion products and
// is busy until the new matrix is stored. A payload word (s_kind high)
// subtracts the stored position, rotates the difference into the vehicle
// frame (transpose of the stored rotation), negates y and z, saturates, and
// passes the payload quaternion through on the m_ channel.
// A payload word passes through the three serial dot-product lanes (one bit of
// each difference a cycle), a rounding step and a saturation step; the next
// word is taken only once the result has moved to the output register.
// s_ready is high whenever the sequencer is idle; a result waiting in the
// output register does not hold off the next word. If the receiver stalls,
// the following payload result waits in the saturation step until the output
// register frees.
// Reset (aresetn low, synchronous) empties the output and sets the pose to
// zero position with identity attitude; no clearing pass is needed.
module body_frame_relative_position
    import bfrp_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int QUAT_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic signed [POS_WIDTH-1:0]  s_pos_x,
    input  logic signed [POS_WIDTH-1:0]  s_pos_y,
    input  logic signed [POS_WIDTH-1:0]  s_pos_z,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_w,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_x,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_y,
    input  logic signed [QUAT_WIDTH-1:0] s_quat_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [POS_WIDTH-1:0]  m_rel_x,
    output logic signed [POS_WIDTH-1:0]  m_rel_y,
    output logic signed [POS_WIDTH-1:0]  m_rel_z,
    output logic signed [QUAT_WIDTH-1:0] m_out_qw,
    output logic signed [QUAT_WIDTH-1:0] m_out_qx,
    output logic signed [QUAT_WIDTH-1:0] m_out_qy,
    output logic signed [QUAT_WIDTH-1:0] m_out_qz
);

    localparam int PW   = POS_WIDTH;
    localparam int QW   = QUAT_WIDTH;
    localparam int QF   = QW - 2;
    localparam int DW   = PW + 1;                 // difference width
    localparam int MW   = MAT_FRAC + 7;           // matrix element width, any QW
    localparam int QPW  = QW + 4 + QW;            // quaternion lane output
    localparam int PPW  = MW + 4 + DW;            // dot-product lane output
    localparam int RW   = PPW - MAT_FRAC;         // rounded sum width
    localparam int SHR  = (2 * QF > MAT_FRAC) ? (2 * QF - MAT_FRAC) : 0;
    localparam int SHL  = (2 * QF < MAT_FRAC) ? (MAT_FRAC - 2 * QF) : 0;
    localparam int EW   = 2 * QW + SHL;
    localparam int CW   = $clog2(PW + QW + 2);

    localparam logic signed [MW-1:0]  ONE  = MW'(1) <<< MAT_FRAC;
    localparam logic signed [PPW-1:0] HALF = PPW'(1) <<< (MAT_FRAC - 1);
    localparam logic signed [RW:0]    PMAX = (RW + 1)'((64'sd1 <<< (PW - 1)) - 64'sd1);
    localparam logic signed [RW:0]    PMIN = -PMAX - (RW + 1)'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QMUL,
        ST_QMAT,
        ST_PMUL,
        ST_PRND,
        ST_PSAT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;

    // Stored pose
    logic signed [PW-1:0] vpos_reg [3];
    logic signed [QW-1:0] att_reg  [4];
    logic signed [MW-1:0] mat_reg  [3][3];   // [lane][term]: column of R

    // Serial operands
    logic [QW-1:0] qsh_reg [3];              // x, y, z shifted out LSB first
    logic [DW-1:0] dsh_reg [3];

    logic signed [QW-1:0] qp_reg [4];        // payload quaternion held
    logic signed [RW-1:0] rnd_reg [3];

    logic                 m_valid_reg;
    logic signed [PW-1:0] rel_reg [3];
    logic signed [QW-1:0] oq_reg  [4];

    logic accept;
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Lane control
    mac_ctl_t qctl, pctl;
    always_comb begin
        qctl.clr  = accept;
        qctl.en   = (state_reg == ST_QMUL);
        qctl.last = (count_reg == CW'(QW - 1));
        pctl.clr  = accept;
        pctl.en   = (state_reg == ST_PMUL);
        pctl.last = (count_reg == CW'(DW - 1));
    end

    // Quaternion products: xx yy zz xy xz yz wx wy wz
    logic signed [QW-1:0]  qa   [9];
    logic [2:0]            qb   [9];
    logic signed [QPW-1:0] qprod [9];

    always_comb begin
        qa[0] = att_reg[1]; qb[0] = {2'b00, qsh_reg[0][0]};
        qa[1] = att_reg[2]; qb[1] = {2'b00, qsh_reg[1][0]};
        qa[2] = att_reg[3]; qb[2] = {2'b00, qsh_reg[2][0]};
        qa[3] = att_reg[1]; qb[3] = {2'b00, qsh_reg[1][0]};
        qa[4] = att_reg[1]; qb[4] = {2'b00, qsh_reg[2][0]};
        qa[5] = att_reg[2]; qb[5] = {2'b00, qsh_reg[2][0]};
        qa[6] = att_reg[0]; qb[6] = {2'b00, qsh_reg[0][0]};
        qa[7] = att_reg[0]; qb[7] = {2'b00, qsh_reg[1][0]};
        qa[8] = att_reg[0]; qb[8] = {2'b00, qsh_reg[2][0]};
    end

    for (genvar i = 0; i < 9; i++) begin : g_qlane
        bfrp_mac #(.AW(QW), .NB(QW)) u_qmac (
            .aclk (aclk),
            .ctl  (qctl),
            .a0   (qa[i]),
            .a1   ('0),
            .a2   ('0),
            .b    (qb[i]),
            .prod (qprod[i])
        );
    end

    // Products brought to Q28
    logic signed [EW-1:0] qext [9];
    logic signed [MW-1:0] q28  [9];
    logic signed [MW-1:0] mat_next [3][3];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            qext[i] = EW'(signed'(qprod[i][2*QW-1:0])) <<< SHL;
            q28[i]  = MW'(qext[i] >>> SHR);
        end
        mat_next[0][0] = ONE - ((q28[1] + q28[2]) <<< 1);
        mat_next[0][1] = (q28[3] + q28[8]) <<< 1;
        mat_next[0][2] = (q28[4] - q28[7]) <<< 1;
        mat_next[1][0] = (q28[3] - q28[8]) <<< 1;
        mat_next[1][1] = ONE - ((q28[0] + q28[2]) <<< 1);
        mat_next[1][2] = (q28[5] + q28[6]) <<< 1;
        mat_next[2][0] = (q28[4] + q28[7]) <<< 1;
        mat_next[2][1] = (q28[5] - q28[6]) <<< 1;
        mat_next[2][2] = ONE - ((q28[0] + q28[1]) <<< 1);
    end

    // Rotation lanes, one per output axis
    logic signed [PPW-1:0] pprod [3];

    for (genvar j = 0; j < 3; j++) begin : g_plane
        bfrp_mac #(.AW(MW), .NB(DW)) u_pmac (
            .aclk (aclk),
            .ctl  (pctl),
            .a0   (mat_reg[j][0]),
            .a1   (mat_reg[j][1]),
            .a2   (mat_reg[j][2]),
            .b    ({dsh_reg[2][0], dsh_reg[1][0], dsh_reg[0][0]}),
            .prod (pprod[j])
        );
    end

    // Round half up, then negate y and z and saturate
    logic signed [PPW-1:0] rsum [3];
    logic signed [RW:0]    rv   [3];
    logic signed [PW-1:0]  sat  [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rsum[j] = pprod[j] + HALF;
            rv[j]   = (j == 0) ? (RW + 1)'(rnd_reg[j]) : -((RW + 1)'(rnd_reg[j]));
            if (rv[j] > PMAX) begin
                sat[j] = PW'(PMAX);
            end else if (rv[j] < PMIN) begin
                sat[j] = PW'(PMIN);
            end else begin
                sat[j] = rv[j][PW-1:0];
            end
        end
    end

    logic out_free;
    logic load_out;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_PSAT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                vpos_reg[i] <= '0;
                for (int k = 0; k < 3; k++) begin
                    mat_reg[i][k] <= (i == k) ? ONE : '0;
                end
            end
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    count_reg <= '0;
                    if (accept) begin
                        if (!s_kind) begin
                            vpos_reg[0] <= s_pos_x;
                            vpos_reg[1] <= s_pos_y;
                            vpos_reg[2] <= s_pos_z;
                            att_reg[0]  <= s_quat_w;
                            att_reg[1]  <= s_quat_x;
                            att_reg[2]  <= s_quat_y;
                            att_reg[3]  <= s_quat_z;
                            qsh_reg[0]  <= s_quat_x;
                            qsh_reg[1]  <= s_quat_y;
                            qsh_reg[2]  <= s_quat_z;
                            state_reg   <= ST_QMUL;
                        end else begin
                            dsh_reg[0] <= DW'(s_pos_x) - DW'(vpos_reg[0]);
                            dsh_reg[1] <= DW'(s_pos_y) - DW'(vpos_reg[1]);
                            dsh_reg[2] <= DW'(s_pos_z) - DW'(vpos_reg[2]);
                            qp_reg[0]  <= s_quat_w;
                            qp_reg[1]  <= s_quat_x;
                            qp_reg[2]  <= s_quat_y;
                            qp_reg[3]  <= s_quat_z;
                            state_reg  <= ST_PMUL;
                        end
                    end
                end
                ST_QMUL: begin
                    for (int i = 0; i < 3; i++) begin
                        qsh_reg[i] <= qsh_reg[i] >> 1;
                    end
                    count_reg <= count_reg + CW'(1);
                    if (qctl.last) begin
                        state_reg <= ST_QMAT;
                    end
                end
                ST_QMAT: begin
                    mat_reg   <= mat_next;
                    state_reg <= ST_IDLE;
                end
                ST_PMUL: begin
                    for (int i = 0; i < 3; i++) begin
                        dsh_reg[i] <= dsh_reg[i] >> 1;
                    end
                    count_reg <= count_reg + CW'(1);
                    if (pctl.last) begin
                        state_reg <= ST_PRND;
                    end
                end
                ST_PRND: begin
                    for (int j = 0; j < 3; j++) begin
                        rnd_reg[j] <= RW'(rsum[j] >>> MAT_FRAC);
                    end
                    state_reg <= ST_PSAT;
                end
                ST_PSAT: begin
                    if (load_out) begin
                        rel_reg   <= sat;
                        oq_reg    <= qp_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_rel_x  = rel_reg[0];
    assign m_rel_y  = rel_reg[1];
    assign m_rel_z  = rel_reg[2];
    assign m_out_qw = oq_reg[0];
    assign m_out_qx = oq_reg[1];
    assign m_out_qy = oq_reg[2];
    assign m_out_qz = oq_reg[3];

    // A result only appears out of the saturation step.
    a_valid_from_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_PSAT))
        else $error("result raised outside saturation step");

    // A pose update never produces a result.
    a_pose_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QMAT) |=> !$rose(m_valid_reg))
        else $error("pose update produced a result");

    // The bit counter stays within the difference width.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PMUL) |-> (count_reg < CW'(DW)))
        else $error("serial counter overran");

    // A full output register is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(rel_reg[0]) && m_valid_reg)
        else $error("pending result overwritten");

endmodule
